// File: rtl/bat_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and a helper function of the buddy allocator tree
// no dependencies

package bat_pkg;

    localparam int LEVELS_DEF    = 10;
    localparam int POOL_LOG2_DEF = 20;

    localparam int ADDR_W = 48;
    localparam int REQ_W  = 21;
    localparam int CODE_W = 5;
    localparam int NL_W   = 6;
    localparam int CLOG_W = 5;
    localparam int APB_DW = 64;
    localparam int APB_AW = 4;

    // register map, index by paddr[3]
    localparam logic REG_POOL_BASE = 1'b0;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic              granted;
        logic [ADDR_W-1:0] block_address;
    } t_res;

    // ceil(log2(v)), zero for v of zero or one
    function automatic logic [CLOG_W-1:0] ceil_log2_req(input logic [REQ_W-1:0] v);
        logic [REQ_W-1:0]  x;
        logic [CLOG_W-1:0] r;
        x = v - REQ_W'(1);
        r = '0;
        if (v > REQ_W'(1)) begin
            for (int i = 0; i < REQ_W; i++) begin
                if (x[i]) begin
                    r = CLOG_W'(i + 1);
                end
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/bat_tree_ram.sv
`timescale 1ns / 1ps
// node memory of the allocator tree: one write port, one registered read port
// depends on bat_pkg for the entry width

module bat_tree_ram #(
    parameter int LEVELS = bat_pkg::LEVELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [LEVELS-1:0]           i_wr_addr,
    input  logic [bat_pkg::CODE_W-1:0]  i_wr_data,
    input  logic [LEVELS-1:0]           i_rd_addr,
    output logic [bat_pkg::CODE_W-1:0]  o_rd_data
);

    logic [bat_pkg::CODE_W-1:0] r_mem [0:(1 << LEVELS)-1];
    logic [bat_pkg::CODE_W-1:0] r_rd_data;

    // read returns the old entry on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/buddy_allocator_tree_unit.sv
`timescale 1ns / 1ps
// buddy allocator over a power-of-two pool, tree of free-size codes in one memory
// depends on bat_pkg and bat_tree_ram
//
// sequence: a taken start goes through the check, one descent step per level down to
//   the request's block (tree depth 0 .. min(LEVELS-1, POOL_LOG2)), the mark, one climb
//   step per level back to the root, then the result strobe; a refusal goes from the
//   check to the strobe; one request at a time, busy until the result strobe has gone;
//   the descent and the climb each cost one memory access per level through the single read port
// reset: synchronous active-low; afterwards a clearing pass writes the full-size code
//   into all 2^LEVELS-1 nodes, one node a cycle, with busy high; pool_base resets to 0
// results cannot be stalled: o_res is valid for exactly the one cycle o_res_valid is high

module buddy_allocator_tree_unit #(
    parameter int LEVELS    = bat_pkg::LEVELS_DEF,
    parameter int POOL_LOG2 = bat_pkg::POOL_LOG2_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  bat_pkg::t_req                i_req,
    output logic                         o_res_valid,
    output bat_pkg::t_res                o_res,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bat_pkg::APB_AW-1:0]   paddr,
    input  logic [bat_pkg::APB_DW-1:0]   pwdata,
    output logic [bat_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int IDX_W      = LEVELS;
    localparam int DEPTH_W    = $clog2(LEVELS);
    localparam int MAX_DEPTH  = (LEVELS - 1 > POOL_LOG2) ? POOL_LOG2 : LEVELS - 1;
    localparam int MIN_LOG    = POOL_LOG2 - MAX_DEPTH;
    localparam int OFF_W      = POOL_LOG2 + 1;
    localparam int NODE_SLOTS = 1 << LEVELS;
    localparam int CODE_W     = bat_pkg::CODE_W;
    localparam int NL_W       = bat_pkg::NL_W;
    localparam int AW         = bat_pkg::ADDR_W;

    localparam logic [OFF_W-1:0]   HALF0      = OFF_W'(1) << (POOL_LOG2 - 1);
    localparam logic [IDX_W-1:0]   CLR_LAST   = IDX_W'(NODE_SLOTS - 2);
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_D = DEPTH_W'(MAX_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_DESC  = 7'b0001000,
        S_MARK  = 7'b0010000,
        S_CLIMB = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // code of a fully free node at depth d: log2 of its size plus one, kept to 5 bits
    function automatic logic [CODE_W-1:0] full_code(input logic [DEPTH_W-1:0] d);
        logic [7:0] t;
        t = 8'(POOL_LOG2) - 8'(d) + 8'd1;
        return t[CODE_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] sibling(input logic [IDX_W-1:0] idx);
        return idx[0] ? idx + IDX_W'(1) : idx - IDX_W'(1);
    endfunction

    t_state             r_state, n_state;
    logic               r_func, n_func;
    logic [NL_W-1:0]    r_nl, n_nl;
    logic [AW-1:0]      r_rel, n_rel;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [DEPTH_W-1:0] r_level, n_level;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [OFF_W-1:0]   r_half, n_half;
    logic [CODE_W-1:0]  r_cur, n_cur;
    bat_pkg::t_res      r_res, n_res;
    logic [AW-1:0]      r_pool_base, n_pool_base;
    logic [IDX_W-1:0]   r_clr_idx, n_clr_idx;
    logic [DEPTH_W-1:0] r_clr_depth, n_clr_depth;

    // memory port
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [CODE_W-1:0]  w_wr_data;
    logic [IDX_W-1:0]   w_rd_addr;
    logic [CODE_W-1:0]  w_rd_data;

    // helpers
    logic               w_accept;
    logic               w_cfg_wr;
    logic [bat_pkg::CLOG_W-1:0] w_clog;
    logic [NL_W-1:0]    w_need_code;
    logic [NL_W-1:0]    w_level6;
    logic [IDX_W-1:0]   w_left;
    logic               w_go_right;
    logic [IDX_W-1:0]   w_desc_idx;
    logic [DEPTH_W-1:0] w_desc_depth;
    logic [IDX_W-1:0]   w_parent;
    logic [CODE_W-1:0]  w_l, w_r, w_child_full, w_pval;
    logic [IDX_W:0]     w_lvl_last;
    logic [DEPTH_W-1:0] w_clr_code_d;
    logic [CODE_W-1:0]  w_leaf;

    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[3] == bat_pkg::REG_POOL_BASE);

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
    assign pready      = 1'b1;
    assign prdata      = (paddr[3] == bat_pkg::REG_POOL_BASE)
                         ? bat_pkg::APB_DW'(r_pool_base) : '0;

    // log2 of the rounded size of the incoming request, raised to the smallest block when taken
    assign w_clog      = bat_pkg::ceil_log2_req(i_req.request_bytes);
    assign w_need_code = r_nl + NL_W'(1);
    assign w_level6    = NL_W'(POOL_LOG2) - r_nl;

    // descent step: left child first, free requests steer by offset
    assign w_left       = (r_idx << 1) | IDX_W'(1);
    assign w_go_right   = (r_func == bat_pkg::FUNC_ALLOC)
                          ? ({1'b0, w_rd_data} < w_need_code)
                          : (r_rel >= AW'(r_off + r_half));
    assign w_desc_idx   = w_go_right ? w_left + IDX_W'(1) : w_left;
    assign w_desc_depth = r_depth + DEPTH_W'(1);

    // climb step: r_cur is the node just written, the sibling comes from memory
    assign w_parent     = (r_idx - IDX_W'(1)) >> 1;
    assign w_l          = r_idx[0] ? r_cur : w_rd_data;
    assign w_r          = r_idx[0] ? w_rd_data : r_cur;
    assign w_child_full = full_code(r_depth);
    assign w_pval       = (w_l == w_child_full && w_r == w_child_full)
                          ? full_code(r_depth - DEPTH_W'(1))
                          : ((w_l > w_r) ? w_l : w_r);

    assign w_leaf = (r_func == bat_pkg::FUNC_FREE) ? full_code(r_level) : '0;

    // clearing pass: depth goes up after the last node of each level
    assign w_lvl_last   = ((IDX_W+1)'(1) << ((DEPTH_W+1)'(r_clr_depth) + (DEPTH_W+1)'(1)))
                          - (IDX_W+1)'(2);
    assign w_clr_code_d = (r_clr_depth > MAX_DEPTH_D) ? MAX_DEPTH_D : r_clr_depth;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_nl        = r_nl;
        n_rel       = r_rel;
        n_idx       = r_idx;
        n_depth     = r_depth;
        n_level     = r_level;
        n_off       = r_off;
        n_half      = r_half;
        n_cur       = r_cur;
        n_res       = r_res;
        n_pool_base = w_cfg_wr ? pwdata[AW-1:0] : r_pool_base;
        n_clr_idx   = r_clr_idx;
        n_clr_depth = r_clr_depth;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx;
        w_wr_data   = w_pval;
        w_rd_addr   = '0;

        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_idx;
                w_wr_data = full_code(w_clr_code_d);
                n_clr_idx = r_clr_idx + IDX_W'(1);
                if ({1'b0, r_clr_idx} == w_lvl_last) begin
                    n_clr_depth = r_clr_depth + DEPTH_W'(1);
                end
                if (r_clr_idx == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // root is read every idle cycle, ready for the check
                w_rd_addr = '0;
                if (w_accept) begin
                    n_func  = i_req.func;
                    n_nl    = (NL_W'(w_clog) < NL_W'(MIN_LOG)) ? NL_W'(MIN_LOG) : NL_W'(w_clog);
                    n_rel   = i_req.free_address - r_pool_base;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                w_rd_addr = IDX_W'(1);
                n_idx     = '0;
                n_depth   = '0;
                n_off     = '0;
                n_half    = HALF0;
                n_level   = w_level6[DEPTH_W-1:0];
                n_res     = '0;
                if (r_nl > NL_W'(POOL_LOG2)) begin
                    n_state = S_DONE;
                end else if (r_func == bat_pkg::FUNC_ALLOC &&
                             {1'b0, w_rd_data} < w_need_code) begin
                    n_state = S_DONE;
                end else if (w_level6 == '0) begin
                    n_state = S_MARK;
                end else begin
                    n_state = S_DESC;
                end
            end
            S_DESC: begin
                n_idx     = w_desc_idx;
                n_depth   = w_desc_depth;
                n_off     = w_go_right ? r_off + r_half : r_off;
                n_half    = r_half >> 1;
                w_rd_addr = (w_desc_idx << 1) | IDX_W'(1);
                if (w_desc_depth == r_level) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                w_wr_data = w_leaf;
                n_cur     = w_leaf;
                w_rd_addr = sibling(r_idx);
                n_res.granted       = 1'b1;
                n_res.block_address = (r_func == bat_pkg::FUNC_FREE)
                                      ? '0 : r_pool_base + AW'(r_off);
                n_state = (r_depth == '0) ? S_DONE : S_CLIMB;
            end
            S_CLIMB: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_parent;
                w_wr_data = w_pval;
                n_cur     = w_pval;
                n_idx     = w_parent;
                n_depth   = r_depth - DEPTH_W'(1);
                w_rd_addr = sibling(w_parent);
                if (r_depth == DEPTH_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_clr_depth <= '0;
            r_pool_base <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_clr_depth <= n_clr_depth;
            r_pool_base <= n_pool_base;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_nl    <= n_nl;
        r_rel   <= n_rel;
        r_idx   <= n_idx;
        r_depth <= n_depth;
        r_level <= n_level;
        r_off   <= n_off;
        r_half  <= n_half;
        r_cur   <= n_cur;
        r_res   <= n_res;
    end

    bat_tree_ram #(
        .LEVELS (LEVELS)
    ) u_tree_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule
